// ----- hdl/stba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package stba_pkg;

	localparam int unsigned OpW    = 1;
	localparam int unsigned SideW  = 6;
	localparam int unsigned CountW = 6;
	localparam int unsigned AtlasW = 2;
	localparam int unsigned CellW  = 5;
	localparam int unsigned CfgW   = 6;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic REG_GRID  = 1'b0;
	localparam logic REG_ATLAS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BAND,
		ST_RD,
		ST_ACC,
		ST_COL,
		ST_CM_RP,
		ST_CM_LD,
		ST_CM_RD,
		ST_CM_WR
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/stba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module stba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/square_tile_bitmap_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Allocates request_count aligned squares of tile_cells cells from per-atlas occupancy
// bitmaps held in a row memory, all or none; a clear empties every atlas by resetting the
// per-row valid flags. Results appear one per cycle at most, each for one cycle
// on done, and cannot be stalled. Busy rises the cycle after an allocation is accepted
// and falls as its last result is issued; clear and rejected requests never raise it.
// Timing is set by the single-read-port row memory: each row band starts in ST_BAND,
// reads its rows through ST_RD and ST_ACC, then steps through the columns in ST_COL;
// a successful commit loads each square from the pending list (ST_CM_RP, ST_CM_LD) and
// reads and rewrites each of its rows (ST_CM_RD, ST_CM_WR). Clear and rejected requests
// are answered straight from idle.
module square_tile_bitmap_allocator #(
	parameter int unsigned GRID_MAX    = 32,
	parameter int unsigned ATLASES     = 4,
	parameter int unsigned MAX_REQUEST = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [stba_pkg::OpW-1:0]    op,
	input  wire logic [stba_pkg::SideW-1:0]  tile_cells,
	input  wire logic [stba_pkg::CountW-1:0] request_count,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [stba_pkg::CfgW-1:0]   cfg_wdata,
	output logic                             done,
	output logic                             ok,
	output logic [stba_pkg::AtlasW-1:0]      atlas_index,
	output logic [stba_pkg::CellW-1:0]       x_cell,
	output logic [stba_pkg::CellW-1:0]       y_cell,
	output logic                             last
);
	import stba_pkg::*;

	localparam int unsigned AW    = (ATLASES > 1) ? $clog2(ATLASES) : 1;
	localparam int unsigned DEPTH = ATLASES * GRID_MAX;
	localparam int unsigned RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned PW    = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
	localparam int unsigned PD    = 1 << PW;
	localparam int unsigned PEW   = AW + 2 * CellW;

	function automatic logic [GRID_MAX-1:0] sq_mask(input logic [5:0] x, input logic [5:0] s);
		logic [GRID_MAX-1:0] ones;
		ones = {GRID_MAX{1'b1}} >> (7'(GRID_MAX) - {1'b0, s});
		return ones << x;
	endfunction

	state_t state_q, state_d;

	logic [5:0] grid_q;
	logic [2:0] atlas_q;
	logic [5:0] side_q;
	logic [5:0] want_q;
	logic [4:0] a_q;
	logic [5:0] y_q, x_q, r_q;
	logic [6:0] found_q, k_q;
	logic [GRID_MAX-1:0] acc_q;
	logic [AW-1:0]    pa_q;
	logic [CellW-1:0] px_q, py_q;
	logic [DEPTH-1:0] vld_q;
	logic             rvld_s1;

	logic [5:0] grid;
	logic [4:0] ac;
	logic       req_bad;
	logic [6:0] y_end, x_end, r_nx;
	logic [AW-1:0] row_a;
	logic [5:0]    row_y;
	logic [RAW-1:0] row_addr;
	logic [GRID_MAX-1:0] row_rdata, row_data;
	logic [PEW-1:0] pend_rdata, pend_wdata;
	logic           pend_we;
	logic           row_we;
	logic [GRID_MAX-1:0] row_wdata;
	logic           sq_free;
	logic           emit, emit_ok, emit_last;

	assign grid    = (grid_q > 6'(GRID_MAX)) ? 6'(GRID_MAX) : grid_q;
	assign ac      = (5'(atlas_q) > 5'(ATLASES)) ? 5'(ATLASES) : 5'(atlas_q);
	assign req_bad = (tile_cells == '0) || (tile_cells > grid) || (request_count == '0)
		|| (7'(request_count) > 7'(MAX_REQUEST));
	assign y_end   = {1'b0, y_q} + {1'b0, side_q};
	assign x_end   = {1'b0, x_q} + {1'b0, side_q};
	assign r_nx    = {1'b0, r_q} + 7'd1;
	assign sq_free = (acc_q & sq_mask(x_q, side_q)) == '0;

	assign row_a    = (state_q == ST_CM_RD || state_q == ST_CM_WR) ? pa_q : a_q[AW-1:0];
	assign row_y    = (state_q == ST_CM_RD || state_q == ST_CM_WR)
		? (6'(py_q) + r_q) : (y_q + r_q);
	assign row_addr = RAW'(32'(row_a) * GRID_MAX + 32'(row_y));
	assign row_data = rvld_s1 ? row_rdata : '0;
	assign row_we    = (state_q == ST_CM_WR);
	assign row_wdata = row_data | sq_mask(6'(px_q), side_q);
	assign pend_we    = (state_q == ST_COL) && (x_end <= {1'b0, grid}) && sq_free;
	assign pend_wdata = {a_q[AW-1:0], x_q[CellW-1:0], y_q[CellW-1:0]};
	assign busy = (state_q != ST_IDLE);

	stba_ram #(.WIDTH(GRID_MAX), .DEPTH(DEPTH)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_addr),
		.wdata (row_wdata),
		.raddr (row_addr),
		.rdata (row_rdata)
	);

	stba_ram #(.WIDTH(PEW), .DEPTH(PD)) u_pend (
		.clk   (clk),
		.we    (pend_we),
		.waddr (found_q[PW-1:0]),
		.wdata (pend_wdata),
		.raddr (k_q[PW-1:0]),
		.rdata (pend_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && op == OP_ALLOC && !req_bad) begin
					state_d = ST_BAND;
				end
			end
			ST_BAND: begin
				if (a_q >= ac) begin
					state_d = ST_IDLE;
				end else if (y_end <= {1'b0, grid}) begin
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_ACC;
			ST_ACC: state_d = (r_nx < {1'b0, side_q}) ? ST_RD : ST_COL;
			ST_COL: begin
				if (x_end > {1'b0, grid}) begin
					state_d = ST_BAND;
				end else if (sq_free && (found_q + 7'd1 == {1'b0, want_q})) begin
					state_d = ST_CM_RP;
				end
			end
			ST_CM_RP: state_d = ST_CM_LD;
			ST_CM_LD: state_d = ST_CM_RD;
			ST_CM_RD: state_d = ST_CM_WR;
			ST_CM_WR: begin
				if (r_nx < {1'b0, side_q}) begin
					state_d = ST_CM_RD;
				end else if (k_q + 7'd1 == found_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_CM_RP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_ok   = 1'b0;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (start && (op == OP_CLEAR || req_bad)) begin
					emit    = 1'b1;
					emit_ok = (op == OP_CLEAR);
				end
			end
			ST_BAND: begin
				emit = (a_q >= ac);
			end
			ST_CM_WR: begin
				if (r_nx >= {1'b0, side_q}) begin
					emit      = 1'b1;
					emit_ok   = 1'b1;
					emit_last = (k_q + 7'd1 == found_q);
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grid_q  <= 6'd32;
			atlas_q <= 3'd4;
			vld_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit;
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID:  grid_q  <= cfg_wdata;
					REG_ATLAS: atlas_q <= cfg_wdata[2:0];
					default:   grid_q  <= grid_q;
				endcase
			end
			if (state_q == ST_IDLE && start && op == OP_CLEAR) begin
				vld_q <= '0;
			end else if (row_we) begin
				vld_q[row_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rvld_s1 <= vld_q[row_addr];
		if (emit) begin
			ok          <= emit_ok;
			last        <= emit_last;
			atlas_index <= emit_ok && state_q == ST_CM_WR ? AtlasW'(pa_q) : '0;
			x_cell      <= emit_ok && state_q == ST_CM_WR ? px_q : '0;
			y_cell      <= emit_ok && state_q == ST_CM_WR ? py_q : '0;
		end
		case (state_q)
			ST_IDLE: begin
				side_q  <= tile_cells;
				want_q  <= request_count;
				a_q     <= '0;
				y_q     <= '0;
				found_q <= '0;
			end
			ST_BAND: begin
				r_q   <= '0;
				acc_q <= '0;
				if (y_end > {1'b0, grid}) begin
					a_q <= a_q + 5'd1;
					y_q <= '0;
				end
			end
			ST_ACC: begin
				acc_q <= acc_q | row_data;
				r_q   <= r_nx[5:0];
				x_q   <= '0;
			end
			ST_COL: begin
				if (x_end > {1'b0, grid}) begin
					y_q <= y_end[5:0];
				end else begin
					x_q <= x_end[5:0];
					if (sq_free) begin
						found_q <= found_q + 7'd1;
					end
				end
				k_q <= '0;
			end
			ST_CM_LD: begin
				{pa_q, px_q, py_q} <= pend_rdata;
				r_q <= '0;
			end
			ST_CM_WR: begin
				r_q <= r_nx[5:0];
				if (r_nx >= {1'b0, side_q}) begin
					k_q <= k_q + 7'd1;
				end
			end
			default: r_q <= r_q;
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/stba_checker.sv -----
`timescale 1ns / 1ps
module stba_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [stba_pkg::OpW-1:0]    op,
	input  wire logic [stba_pkg::SideW-1:0]  tile_cells,
	input  wire logic [stba_pkg::CountW-1:0] request_count,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [stba_pkg::CfgW-1:0]   cfg_wdata,
	input  wire logic                        done,
	input  wire logic                        ok,
	input  wire logic [stba_pkg::AtlasW-1:0] atlas_index,
	input  wire logic [stba_pkg::CellW-1:0]  x_cell,
	input  wire logic [stba_pkg::CellW-1:0]  y_cell,
	input  wire logic                        last,
	output int                               pending,
	output int                               failures
);
	import stba_pkg::*;

	localparam int GRID_MAX    = 32;
	localparam int ATLASES     = 4;
	localparam int MAX_REQUEST = 32;

	typedef struct packed {
		logic                ok;
		logic [AtlasW-1:0]   atlas;
		logic [CellW-1:0]    x;
		logic [CellW-1:0]    y;
		logic                last;
	} placement_t;

	logic [31:0] bitmap [ATLASES][GRID_MAX];
	logic [5:0]  grid_reg;
	logic [2:0]  atlas_reg;
	placement_t  placements [$];

	function automatic logic [31:0] span_mask(int x, int side);
		logic [31:0] m;
		m = (side >= 32) ? 32'hFFFF_FFFF : ((32'd1 << side) - 32'd1);
		return m << x;
	endfunction

	task automatic allocate(logic [OpW-1:0] o, int side, int want);
		logic [31:0] trial [ATLASES][GRID_MAX];
		placement_t  found [$];
		placement_t  p;
		logic [31:0] m;
		int          grid, ac, a, x, y, r;
		bit          fits, enough;
		grid   = (grid_reg > GRID_MAX) ? GRID_MAX : grid_reg;
		ac     = (atlas_reg > ATLASES) ? ATLASES : atlas_reg;
		enough = 0;
		p      = '0;
		p.last = 1'b1;
		if (o == OP_CLEAR) begin
			foreach (bitmap[i, j]) bitmap[i][j] = '0;
			p.ok = 1'b1;
			placements = {placements, p};
			return;
		end
		if (side == 0 || side > grid || want == 0 || want > MAX_REQUEST) begin
			placements = {placements, p};
			return;
		end
		trial = bitmap;
		for (a = 0; a < ac && !enough; a++)
			for (y = 0; y + side <= grid && !enough; y += side)
				for (x = 0; x + side <= grid && !enough; x += side) begin
					m    = span_mask(x, side);
					fits = 1;
					for (r = y; r < y + side; r++)
						if ((trial[a][r] & m) != 0) fits = 0;
					if (fits) begin
						for (r = y; r < y + side; r++) trial[a][r] |= m;
						p.ok    = 1'b1;
						p.atlas = AtlasW'(a);
						p.x     = CellW'(x);
						p.y     = CellW'(y);
						p.last  = 1'b0;
						found   = {found, p};
						if (found.size() == want) enough = 1;
					end
				end
		if (!enough) begin
			p = '0;
			p.last = 1'b1;
			placements = {placements, p};
			return;
		end
		bitmap = trial;
		found[found.size()-1].last = 1'b1;
		placements = {placements, found};
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t e;
		if (!arst_n) begin
			foreach (bitmap[i, j]) bitmap[i][j] = '0;
			grid_reg  = 6'd32;
			atlas_reg = 3'd4;
			placements.delete();
			failures  = 0;
		end else begin
			if (done) begin
				if (placements.size() == 0) begin
					$display("%0t: unexpected transaction,",
						$time,
						" actual ok=%b atlas=%0d x=%0d y=%0d last=%b",
						ok, atlas_index, x_cell, y_cell, last);
					failures++;
				end else begin
					e = placements.pop_front();
					if (e != {ok, atlas_index, x_cell, y_cell, last}) begin
						$display("%0t: expected ok=%b atlas=%0d x=%0d y=%0d last=%b,",
							$time, e.ok, e.atlas, e.x, e.y, e.last,
							" actual ok=%b atlas=%0d x=%0d y=%0d last=%b",
							ok, atlas_index, x_cell, y_cell, last);
						failures++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_GRID) grid_reg = cfg_wdata;
				else atlas_reg = cfg_wdata[2:0];
			end
			if (start && !busy) allocate(op, tile_cells, request_count);
		end
		pending = placements.size();
	end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import stba_pkg::*;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                start = 0;
	logic                busy;
	logic [OpW-1:0]      op = OP_ALLOC;
	logic [SideW-1:0]    tile_cells = '0;
	logic [CountW-1:0]   request_count = '0;
	logic                cfg_we = 0;
	logic                cfg_index = REG_GRID;
	logic [CfgW-1:0]     cfg_wdata = '0;
	logic                done, ok, last;
	logic [AtlasW-1:0]   atlas_index;
	logic [CellW-1:0]    x_cell, y_cell;
	int                  pending, failures;
	int                  sent = 0;
	int                  grid_now = 32;

	square_tile_bitmap_allocator dut (.*);
	stba_checker u_checker (.*);

	initial forever #1 clk = ~clk;

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic request(logic [OpW-1:0] o, int side, int cnt);
		int idle_pct;
		idle_pct = (sent < 77) ? 26 : (sent < 154) ? 46 : 0;
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start         <= 1;
		op            <= o;
		tile_cells    <= SideW'(side);
		request_count <= CountW'(cnt);
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain();
		start <= 0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(logic idx, int val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_wdata <= CfgW'(val);
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_GRID) grid_now = (val > 32) ? 32 : val;
	endtask

	task automatic random_items(int n);
		int r, side, g;
		g = (grid_now < 1) ? 1 : grid_now;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 7)
				request(OP_CLEAR, $urandom_range(63), $urandom_range(63));
			else if (r < 17)
				request(OP_ALLOC, $urandom_range(63), $urandom_range(63));
			else begin
				side = $urandom_range(1) ? $urandom_range(1, (g < 6) ? g : 6)
					: $urandom_range(1, g);
				request(OP_ALLOC, side,
					$urandom_range(3) ? $urandom_range(1, 6) : $urandom_range(1, 32));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		request(OP_CLEAR, 0, 0);
		request(OP_ALLOC, 32, 1);
		request(OP_ALLOC, 32, 3);
		request(OP_ALLOC, 32, 1);
		request(OP_ALLOC, 0, 1);
		request(OP_ALLOC, 33, 1);
		request(OP_ALLOC, 63, 63);
		request(OP_ALLOC, 1, 0);
		request(OP_ALLOC, 1, 33);
		request(OP_ALLOC, 16, 63);
		request(OP_CLEAR, 63, 63);
		request(OP_ALLOC, 1, 32);
		request(OP_ALLOC, 16, 4);
		request(OP_ALLOC, 8, 32);
		request(OP_ALLOC, 31, 1);
		request(OP_CLEAR, 0, 0);
		drain();

		set_reg(REG_GRID, 0);
		set_reg(REG_ATLAS, 0);
		request(OP_ALLOC, 1, 1);
		drain();
		set_reg(REG_ATLAS, 7);
		request(OP_ALLOC, 1, 1);
		drain();
		set_reg(REG_GRID, 63);
		request(OP_ALLOC, 32, 5);
		request(OP_ALLOC, 32, 1);
		drain();
		set_reg(REG_GRID, 1);
		set_reg(REG_ATLAS, 1);
		request(OP_CLEAR, 0, 0);
		request(OP_ALLOC, 1, 1);
		request(OP_ALLOC, 1, 1);
		request(OP_ALLOC, 2, 1);
		drain();

		set_reg(REG_GRID, 32);
		set_reg(REG_ATLAS, 4);
		random_items(55);
		drain();
		set_reg(REG_GRID, 12);
		set_reg(REG_ATLAS, 2);
		random_items(55);
		drain();
		set_reg(REG_GRID, 5);
		set_reg(REG_ATLAS, 3);
		random_items(48);
		drain();
		set_reg(REG_GRID, 20);
		set_reg(REG_ATLAS, 1);
		random_items(48);
		drain();

		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
